// ----- rtl/rmst_pkg.sv -----
// Package for the range maximum segment tree.
// Holds field widths, constants and the beat structs; no dependencies.
package rmst_pkg;

    localparam int CFG_W  = 11;
    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;

    localparam int LEAVES_DEFAULT = 1024;

    localparam logic [CFG_W-1:0]  COUNT_RESET = 11'd1024;
    localparam logic [DATA_W-1:0] MOST_NEG    = 32'h8000_0000;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef struct packed {
        logic                     func;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         query_low;
        logic [IDX_W-1:0]         query_high;
    } in_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] max_value;
        logic                     empty_range;
        logic                     bad_index;
    } out_beat_t;

endpackage

// ----- rtl/range_max_segment_tree.sv -----
// Range maximum segment tree: point update, inclusive range max query.
// An update writes the leaf and then walks to the root; a query walks both bounds up
// the tree; a bad index or an empty range goes straight to the result. Every step is one
// single-port node memory access. One item at a time; the next beat is taken once the
// result is registered. Synchronous active-low reset, then a clearing pass writes the
// most negative value to every node before any beat.
// Depends on rmst_pkg.
module range_max_segment_tree
    import rmst_pkg::*;
#(
    parameter int LEAVES = LEAVES_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_beat_t         s_beat,
    output logic             m_valid,
    input  logic             m_ready,
    output out_beat_t        m_beat,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int LVL   = $clog2(LEAVES);
    localparam int AW    = LVL + 1;
    localparam int NODES = 2 * LEAVES;
    localparam int CNT_W = LVL + 1;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int SUM_W = CMP_W + 1;

    localparam logic [CMP_W-1:0] LEAVES_C  = CMP_W'(LEAVES);
    localparam logic [AW-1:0]    CLR_LAST  = AW'(NODES - 1);
    localparam logic [AW-1:0]    ROOT_NODE = AW'(1);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_LEAF   = 8'b0000_0100,
        S_UREAD  = 8'b0000_1000,
        S_UWRITE = 8'b0001_0000,
        S_QLEFT  = 8'b0010_0000,
        S_QRIGHT = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]         count_reg;
    logic [AW-1:0]            clr_reg, clr_next;
    logic [AW-1:0]            p_reg, p_next;
    logic signed [DATA_W-1:0] cur_reg, cur_next;
    logic [AW:0]              l_reg, l_next;
    logic [AW:0]              r_reg, r_next;
    logic signed [DATA_W-1:0] best_reg, best_next;
    logic                     pend_reg, pend_next;
    logic                     empty_reg, empty_next;
    logic                     bad_reg, bad_next;
    logic                     m_valid_reg, m_valid_next;
    out_beat_t                m_beat_reg, m_beat_next;

    logic [DATA_W-1:0] mem [NODES];
    logic [DATA_W-1:0] mem_rdata;
    logic [AW-1:0]     mem_addr;
    logic              mem_we;
    logic [DATA_W-1:0] mem_wdata;

    logic [CMP_W-1:0]         count_ext, cnt_eff, idx_ext, qlo_ext, qhi_ext, hi_clip;
    logic                     q_empty;
    logic signed [DATA_W-1:0] rd_val, best_acc, up_max;
    logic [AW:0]              r_dec;
    logic                     accept;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_beat    = m_beat_reg;

    assign count_ext = CMP_W'(count_reg);
    assign cnt_eff   = (count_ext > LEAVES_C) ? LEAVES_C : count_ext;
    assign idx_ext   = CMP_W'(s_beat.index);
    assign qlo_ext   = CMP_W'(s_beat.query_low);
    assign qhi_ext   = CMP_W'(s_beat.query_high);
    assign hi_clip   = (qhi_ext > cnt_eff - CMP_W'(1)) ? cnt_eff - CMP_W'(1) : qhi_ext;
    assign q_empty   = (cnt_eff == '0) || (qlo_ext > hi_clip);

    assign rd_val   = $signed(mem_rdata);
    assign best_acc = (pend_reg && rd_val > best_reg) ? rd_val : best_reg;
    assign up_max   = (rd_val > cur_reg) ? rd_val : cur_reg;
    assign r_dec    = r_reg[0] ? r_reg - (AW+1)'(1) : r_reg;

    always_comb begin
        mem_addr  = p_reg;
        mem_we    = 1'b0;
        mem_wdata = cur_reg;
        unique case (state_reg)
            S_CLEAR: begin
                mem_addr  = clr_reg;
                mem_we    = 1'b1;
                mem_wdata = MOST_NEG;
            end
            S_LEAF: begin
                mem_addr = p_reg;
                mem_we   = 1'b1;
            end
            S_UREAD:  mem_addr = p_reg ^ AW'(1);
            S_UWRITE: begin
                mem_addr  = p_reg >> 1;
                mem_we    = 1'b1;
                mem_wdata = up_max;
            end
            S_QLEFT:  mem_addr = AW'(l_reg);
            S_QRIGHT: mem_addr = AW'(r_reg - (AW+1)'(1));
            default:  mem_addr = p_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_addr];
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        p_next       = p_reg;
        cur_next     = cur_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        best_next    = best_acc;
        pend_next    = 1'b0;
        empty_next   = empty_reg;
        bad_next     = bad_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_beat_next  = m_beat_reg;
        unique case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == CLR_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    empty_next = 1'b0;
                    bad_next   = 1'b0;
                    if (s_beat.func == FUNC_UPDATE) begin
                        best_next = '0;
                        p_next    = AW'(SUM_W'(idx_ext) + SUM_W'(LEAVES_C));
                        cur_next  = s_beat.value;
                        if (idx_ext >= cnt_eff) begin
                            bad_next   = 1'b1;
                            state_next = S_DONE;
                        end else begin
                            state_next = S_LEAF;
                        end
                    end else begin
                        best_next = MOST_NEG;
                        l_next    = (AW+1)'(SUM_W'(qlo_ext) + SUM_W'(LEAVES_C));
                        r_next    = (AW+1)'(SUM_W'(hi_clip) + SUM_W'(LEAVES_C) + SUM_W'(1));
                        if (q_empty) begin
                            empty_next = 1'b1;
                            state_next = S_DONE;
                        end else begin
                            state_next = S_QLEFT;
                        end
                    end
                end
            end
            S_LEAF:   state_next = S_UREAD;
            S_UREAD: begin
                state_next = (p_reg == ROOT_NODE) ? S_DONE : S_UWRITE;
            end
            S_UWRITE: begin
                cur_next   = up_max;
                p_next     = p_reg >> 1;
                state_next = S_UREAD;
            end
            S_QLEFT: begin
                if (l_reg >= r_reg) begin
                    state_next = S_DONE;
                end else begin
                    if (l_reg[0]) begin
                        pend_next = 1'b1;
                        l_next    = l_reg + (AW+1)'(1);
                    end
                    state_next = S_QRIGHT;
                end
            end
            S_QRIGHT: begin
                pend_next  = r_reg[0];
                l_next     = l_reg >> 1;
                r_next     = r_dec >> 1;
                state_next = S_QLEFT;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_beat_next.max_value   = best_reg;
                    m_beat_next.empty_range = empty_reg;
                    m_beat_next.bad_index   = bad_reg;
                    state_next              = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            count_reg   <= COUNT_RESET;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p_reg      <= p_next;
        cur_reg    <= cur_next;
        l_reg      <= l_next;
        r_reg      <= r_next;
        best_reg   <= best_next;
        empty_reg  <= empty_next;
        bad_reg    <= bad_next;
        m_beat_reg <= m_beat_next;
    end

`ifndef SYNTH
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input beat taken while an item is in flight");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_beat.empty_range && m_beat.bad_index))
        else $error("result flags empty and bad together");

    a_walk_no_node0: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && state_reg != S_CLEAR) |-> (mem_addr != '0))
        else $error("tree walk writes the unused node");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_beat.bad_index) |-> (m_beat.max_value == '0))
        else $error("bad update carries a non-zero value");
`endif

endmodule

// ----- tb/range_max_segment_tree_test.sv -----
// Self-checking testbench for range_max_segment_tree: point updates, clipped range max queries.
// Keeps its own copy of the max tree and element count to predict each result beat.
// Depends on rmst_pkg and the range_max_segment_tree RTL.
module range_max_segment_tree_test;
    import rmst_pkg::*;

    localparam int LEAVES       = LEAVES_DEFAULT;
    localparam int SETTLE       = 32;
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_REPORTS  = 10;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    in_beat_t          s_beat;
    logic              m_valid;
    logic              m_ready;
    out_beat_t         m_beat;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;

    logic signed [DATA_W-1:0] node_max [0:2*LEAVES-1];
    logic [CFG_W-1:0]         count_model;
    out_beat_t                pending_results[$];

    bit          quiet;
    int unsigned cycles;
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned updates_seen;
    int unsigned queries_seen;
    int unsigned bad_seen;
    int unsigned empty_seen;
    int unsigned count_writes;

    range_max_segment_tree #(
        .LEAVES(LEAVES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_beat   (s_beat),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_beat   (m_beat),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic bit take_gap();
        return !quiet && ($urandom_range(99) < 17);
    endfunction

    function automatic logic signed [DATA_W-1:0] larger(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic out_beat_t predict_beat(input in_beat_t b);
        out_beat_t                r;
        int unsigned              cnt;
        int unsigned              hi;
        int unsigned              l;
        int unsigned              rt;
        int unsigned              p;
        logic signed [DATA_W-1:0] best;
        r = '0;
        cnt = (count_model > LEAVES) ? LEAVES : count_model;
        if (b.func == FUNC_UPDATE) begin
            if (b.index >= cnt) begin
                r.bad_index = 1'b1;
            end else begin
                p = b.index + LEAVES;
                node_max[p] = b.value;
                p = p >> 1;
                while (p >= 1) begin
                    node_max[p] = larger(node_max[2*p], node_max[2*p+1]);
                    p = p >> 1;
                end
            end
            return r;
        end
        hi = 0;
        if (cnt != 0)
            hi = (b.query_high > cnt - 1) ? cnt - 1 : b.query_high;
        if (cnt == 0 || b.query_low > hi) begin
            r.max_value   = MOST_NEG;
            r.empty_range = 1'b1;
            return r;
        end
        l    = b.query_low + LEAVES;
        rt   = hi + LEAVES + 1;
        best = MOST_NEG;
        while (l < rt) begin
            if (l[0]) begin
                best = larger(best, node_max[l]);
                l++;
            end
            if (rt[0]) begin
                rt--;
                best = larger(best, node_max[rt]);
            end
            l  = l >> 1;
            rt = rt >> 1;
        end
        r.max_value = best;
        return r;
    endfunction

    function automatic in_beat_t make_beat(input logic f, input int unsigned idx,
                                           input logic signed [DATA_W-1:0] val,
                                           input int unsigned lo, input int unsigned hi);
        in_beat_t b;
        b.func       = f;
        b.index      = IDX_W'(idx);
        b.value      = val;
        b.query_low  = IDX_W'(lo);
        b.query_high = IDX_W'(hi);
        return b;
    endfunction

    function automatic logic signed [DATA_W-1:0] random_value();
        case ($urandom_range(9))
            0:       return MOST_NEG;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_beat_t random_item(input int unsigned cnt);
        in_beat_t    b;
        int unsigned top;
        b.func       = $urandom_range(1) ? FUNC_QUERY : FUNC_UPDATE;
        b.index      = IDX_W'($urandom_range(1023));
        b.value      = random_value();
        b.query_low  = IDX_W'($urandom_range(1023));
        b.query_high = IDX_W'($urandom_range(1023));
        if (cnt != 0 && $urandom_range(99) < 85) begin
            top          = cnt - 1;
            b.index      = IDX_W'($urandom_range(top));
            b.query_low  = IDX_W'($urandom_range(top));
            b.query_high = $urandom_range(1) ? IDX_W'($urandom_range(top, b.query_low))
                                             : IDX_W'($urandom_range(1023, b.query_low));
        end
        return b;
    endfunction

    task automatic send_beat(input in_beat_t b);
        @(negedge aclk);
        while (take_gap()) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_beat  = b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_beat(b));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] c);
        wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        repeat (SETTLE) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = c;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        count_model = c;
        count_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    always @(negedge aclk) begin
        m_ready = aresetn && !take_gap();
    end

    always @(posedge aclk) begin
        out_beat_t exp_beat;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected result beat: max %0d empty %b bad %b",
                             m_beat.max_value, m_beat.empty_range, m_beat.bad_index);
            end else begin
                exp_beat = pending_results.pop_front();
                results_seen++;
                if (exp_beat.bad_index) bad_seen++;
                if (exp_beat.empty_range) empty_seen++;
                if (m_beat.max_value !== exp_beat.max_value ||
                    m_beat.empty_range !== exp_beat.empty_range ||
                    m_beat.bad_index !== exp_beat.bad_index) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Mismatch on result %0d: expected max %0d empty %b bad %b, got max %0d empty %b bad %b",
                                 results_seen, exp_beat.max_value, exp_beat.empty_range,
                                 exp_beat.bad_index, m_beat.max_value, m_beat.empty_range,
                                 m_beat.bad_index);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            if (s_beat.func == FUNC_UPDATE) updates_seen++;
            else queries_seen++;
        end
    end

    task automatic test_directed_cases();
        // empty tree at the reset count, then extremes and clipping
        send_beat(make_beat(FUNC_QUERY, 0, 0, 0, 1023));
        send_beat(make_beat(FUNC_UPDATE, 0, 32'sh7FFF_FFFF, 0, 0));
        send_beat(make_beat(FUNC_UPDATE, 1023, MOST_NEG, 0, 0));
        send_beat(make_beat(FUNC_UPDATE, 512, -1, 0, 0));
        send_beat(make_beat(FUNC_QUERY, 0, 0, 0, 1023));
        send_beat(make_beat(FUNC_QUERY, 0, 0, 1, 1023));
        send_beat(make_beat(FUNC_QUERY, 0, 0, 1023, 1023));
        send_beat(make_beat(FUNC_QUERY, 0, 0, 5, 3));
        write_count(11'd10);
        send_beat(make_beat(FUNC_UPDATE, 10, 32'sd77, 0, 0));
        send_beat(make_beat(FUNC_UPDATE, 1023, 32'sd77, 0, 0));
        send_beat(make_beat(FUNC_UPDATE, 9, 32'sh1234_5678, 0, 0));
        send_beat(make_beat(FUNC_QUERY, 0, 0, 0, 1023));
        send_beat(make_beat(FUNC_QUERY, 0, 0, 10, 1023));
        send_beat(make_beat(FUNC_QUERY, 0, 0, 1, 9));
        write_count(11'd0);
        send_beat(make_beat(FUNC_QUERY, 0, 0, 0, 0));
        send_beat(make_beat(FUNC_UPDATE, 0, 32'sd5, 0, 0));
        // count above the leaf total saturates and exposes hidden leaves
        write_count(11'd2047);
        send_beat(make_beat(FUNC_QUERY, 0, 0, 10, 1023));
        write_count(11'd1);
        send_beat(make_beat(FUNC_QUERY, 0, 0, 0, 1023));
        send_beat(make_beat(FUNC_UPDATE, 1, 32'sd3, 0, 0));
        send_beat(make_beat(FUNC_UPDATE, 0, MOST_NEG, 0, 0));
        send_beat(make_beat(FUNC_QUERY, 0, 0, 0, 0));
    endtask

    task automatic test_random_traffic();
        int unsigned phase_count [8];
        int unsigned phase_items [8];
        int unsigned eff;
        phase_count = '{1024, $urandom_range(64, 2), 1, 2047, 0,
                        $urandom_range(1023, 65), 2, 1024};
        phase_items = '{250, 150, 40, 150, 20, 150, 40, 200};
        for (int ph = 0; ph < 8; ph++) begin
            write_count(CFG_W'(phase_count[ph]));
            eff   = (phase_count[ph] > LEAVES) ? LEAVES : phase_count[ph];
            quiet = (phase_count[ph] == 2047);
            for (int k = 0; k < phase_items[ph]; k++) begin
                send_beat(random_item(eff));
                if (k % 100 == 99) wait_drained();
            end
            quiet = 1'b0;
        end
    endtask

    task automatic test_drain_pause();
        write_count(CFG_W'($urandom_range(1024, 1)));
        for (int k = 0; k < 30; k++) begin
            send_beat(random_item((count_model > LEAVES) ? LEAVES : count_model));
            // hold until the block has answered everything
            wait_drained();
        end
    endtask

    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_beat    = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        quiet     = 1'b0;
        for (int i = 0; i < 2*LEAVES; i++) node_max[i] = MOST_NEG;
        count_model = COUNT_RESET;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_cases();
        test_random_traffic();
        test_drain_pause();

        @(negedge aclk);
        s_valid = 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        mismatches += pending_results.size();

        $display("Checked %0d results from %0d updates and %0d queries over %0d count settings",
                 results_seen, updates_seen, queries_seen, count_writes + 1);
        $display("Flagged bad indices: %0d, empty ranges: %0d, mismatches: %0d",
                 bad_seen, empty_seen, mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
